### sv/tnal_pkg.sv
// Shared types, field widths and the blob autotile atlas table.
// Used by tnal_map and tile_neighbour_autotile_lookup; depends on nothing.
package tnal_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;

    localparam int X_W    = 5;
    localparam int Y_W    = 5;
    localparam int MASK_W = 8;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 2;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_atlas;

    // Masks missing from the 47-entry set map to column 0, row 0.
    function automatic t_atlas atlas_lookup(input logic [MASK_W-1:0] mask);
        t_atlas a;
        a = '{col: COL_W'(0), row: ROW_W'(0)};
        case (mask)
            8'd0:    a = '{col: 4'd0,  row: 2'd3};
            8'd2:    a = '{col: 4'd0,  row: 2'd2};
            8'd8:    a = '{col: 4'd3,  row: 2'd3};
            8'd10:   a = '{col: 4'd3,  row: 2'd2};
            8'd11:   a = '{col: 4'd11, row: 2'd3};
            8'd16:   a = '{col: 4'd1,  row: 2'd3};
            8'd18:   a = '{col: 4'd1,  row: 2'd2};
            8'd22:   a = '{col: 4'd8,  row: 2'd3};
            8'd24:   a = '{col: 4'd2,  row: 2'd3};
            8'd26:   a = '{col: 4'd2,  row: 2'd2};
            8'd27:   a = '{col: 4'd6,  row: 2'd3};
            8'd30:   a = '{col: 4'd5,  row: 2'd3};
            8'd31:   a = '{col: 4'd9,  row: 2'd3};
            8'd64:   a = '{col: 4'd0,  row: 2'd0};
            8'd66:   a = '{col: 4'd0,  row: 2'd1};
            8'd72:   a = '{col: 4'd3,  row: 2'd0};
            8'd74:   a = '{col: 4'd3,  row: 2'd1};
            8'd75:   a = '{col: 4'd7,  row: 2'd2};
            8'd80:   a = '{col: 4'd1,  row: 2'd0};
            8'd82:   a = '{col: 4'd1,  row: 2'd1};
            8'd86:   a = '{col: 4'd4,  row: 2'd2};
            8'd88:   a = '{col: 4'd2,  row: 2'd0};
            8'd90:   a = '{col: 4'd2,  row: 2'd1};
            8'd91:   a = '{col: 4'd4,  row: 2'd0};
            8'd94:   a = '{col: 4'd7,  row: 2'd0};
            8'd95:   a = '{col: 4'd10, row: 2'd3};
            8'd104:  a = '{col: 4'd11, row: 2'd0};
            8'd106:  a = '{col: 4'd7,  row: 2'd1};
            8'd107:  a = '{col: 4'd11, row: 2'd2};
            8'd120:  a = '{col: 4'd6,  row: 2'd0};
            8'd122:  a = '{col: 4'd4,  row: 2'd3};
            8'd123:  a = '{col: 4'd11, row: 2'd1};
            8'd126:  a = '{col: 4'd9,  row: 2'd1};
            8'd127:  a = '{col: 4'd6,  row: 2'd2};
            8'd208:  a = '{col: 4'd8,  row: 2'd0};
            8'd210:  a = '{col: 4'd4,  row: 2'd1};
            8'd214:  a = '{col: 4'd8,  row: 2'd1};
            8'd216:  a = '{col: 4'd5,  row: 2'd0};
            8'd218:  a = '{col: 4'd7,  row: 2'd3};
            8'd219:  a = '{col: 4'd10, row: 2'd2};
            8'd222:  a = '{col: 4'd8,  row: 2'd2};
            8'd223:  a = '{col: 4'd5,  row: 2'd2};
            8'd248:  a = '{col: 4'd10, row: 2'd0};
            8'd250:  a = '{col: 4'd9,  row: 2'd0};
            8'd251:  a = '{col: 4'd6,  row: 2'd1};
            8'd254:  a = '{col: 4'd5,  row: 2'd1};
            8'd255:  a = '{col: 4'd9,  row: 2'd2};
            default: a = '{col: COL_W'(0), row: ROW_W'(0)};
        endcase
        return a;
    endfunction

endpackage

### sv/tnal_ram.sv
// Generic single-write, single-read RAM with per-bit write mask and registered read.
// Read during write to the same row returns the old contents. No dependencies.
module tnal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wmask,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wmask[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tnal_map.sv
// Solid-bit grid: three row-wide RAM copies read at rows y-1, y, y+1, plus row valid bits.
// Depends on tnal_pkg and tnal_ram.
module tnal_map #(
    parameter int GRID_WIDTH  = tnal_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tnal_pkg::GRID_HEIGHT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic                     i_wr_en,
    input  logic                     i_wr_bit,
    input  logic [tnal_pkg::X_W-1:0] i_x_pos,
    input  logic [tnal_pkg::Y_W-1:0] i_y_pos,
    output logic [GRID_WIDTH-1:0]    o_row_n,
    output logic [GRID_WIDTH-1:0]    o_row_c,
    output logic [GRID_WIDTH-1:0]    o_row_s
);

    localparam int AW = $clog2(GRID_HEIGHT);

    logic [GRID_HEIGHT-1:0] r_row_vld;
    logic                   r_vld_n, r_vld_c, r_vld_s;

    logic [AW-1:0]          addr_n, addr_c, addr_s;
    logic [tnal_pkg::Y_W:0] y_plus;
    logic                   vld_n, vld_c, vld_s;
    logic [GRID_WIDTH-1:0]  onehot, wmask, wdata;
    logic [GRID_WIDTH-1:0]  rd_n, rd_c, rd_s;

    assign y_plus = {1'b0, i_y_pos} + (tnal_pkg::Y_W+1)'(1);
    assign addr_c = AW'(i_y_pos);
    assign addr_n = AW'(i_y_pos - tnal_pkg::Y_W'(1));
    assign addr_s = AW'(y_plus);

    assign vld_c = (int'(addr_c) < GRID_HEIGHT) ? r_row_vld[addr_c] : 1'b0;
    assign vld_n = (int'(addr_n) < GRID_HEIGHT) ? r_row_vld[addr_n] : 1'b0;
    assign vld_s = (int'(addr_s) < GRID_HEIGHT) ? r_row_vld[addr_s] : 1'b0;

    // A row never written reads as zero: write it whole the first time.
    assign onehot = GRID_WIDTH'(1) << i_x_pos;
    assign wmask  = vld_c ? onehot : '1;
    assign wdata  = i_wr_bit ? onehot : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[addr_c] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_vld_n <= vld_n;
            r_vld_c <= vld_c;
            r_vld_s <= vld_s;
        end
    end

    tnal_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_ram_n (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(addr_c),
        .i_wmask(wmask),
        .i_wdata(wdata),
        .i_re   (i_rd_en),
        .i_raddr(addr_n),
        .o_rdata(rd_n)
    );

    tnal_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_ram_c (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(addr_c),
        .i_wmask(wmask),
        .i_wdata(wdata),
        .i_re   (i_rd_en),
        .i_raddr(addr_c),
        .o_rdata(rd_c)
    );

    tnal_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_ram_s (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(addr_c),
        .i_wmask(wmask),
        .i_wdata(wdata),
        .i_re   (i_rd_en),
        .i_raddr(addr_s),
        .o_rdata(rd_s)
    );

    assign o_row_n = r_vld_n ? rd_n : '0;
    assign o_row_c = r_vld_c ? rd_c : '0;
    assign o_row_s = r_vld_s ? rd_s : '0;

endmodule

### sv/tile_neighbour_autotile_lookup.sv
// Blob autotile lookup: an accepted item is held in the stage-1 registers, then in the
// result register. Throughput one item per cycle unless i_ready stalls the output; the
// grid rows are read at the accept edge, the mask and atlas cell are formed in the next
// cycle and held in the result register.
// Reset clears the row valid bits, so the whole grid reads as empty at once;
// no clearing pass. edge_solid resets to 0.
module tile_neighbour_autotile_lookup #(
    parameter int GRID_WIDTH  = tnal_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tnal_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [tnal_pkg::X_W-1:0]    i_x_pos,
    input  logic [tnal_pkg::Y_W-1:0]    i_y_pos,
    input  logic                        i_solid_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_tile_solid,
    output logic [tnal_pkg::MASK_W-1:0] o_neighbour_mask,
    output logic [tnal_pkg::COL_W-1:0]  o_atlas_col,
    output logic [tnal_pkg::ROW_W-1:0]  o_atlas_row
);

    localparam int XW = $clog2(GRID_WIDTH);

    logic                     r_edge_solid;
    logic                     r_s1_vld;
    logic                     r_s1_kind, r_s1_solid_in;
    logic [tnal_pkg::X_W-1:0] r_s1_x;
    logic                     r_s1_in_c, r_s1_ok_n, r_s1_ok_s, r_s1_ok_w, r_s1_ok_e;
    logic                     r_out_vld;
    logic                     r_tile_solid;
    logic [tnal_pkg::MASK_W-1:0] r_mask;
    tnal_pkg::t_atlas         r_atlas;

    logic                     accept, s1_adv, in_grid, wr_en;
    logic [GRID_WIDTH-1:0]    row_n, row_c, row_s;
    logic [XW-1:0]            xc, xw, xe;
    logic                     b_n, b_s, b_w, b_e, b_nw, b_ne, b_sw, b_se, centre;
    logic [tnal_pkg::MASK_W-1:0] n_mask;
    tnal_pkg::t_atlas         n_atlas;

    assign s1_adv  = !r_out_vld || i_ready;
    assign o_ready = !r_s1_vld || s1_adv;
    assign accept  = i_valid && o_ready;
    assign in_grid = (int'(i_x_pos) < GRID_WIDTH) && (int'(i_y_pos) < GRID_HEIGHT);
    assign wr_en   = accept && i_kind && in_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_solid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_edge_solid <= i_cfg_wr_data;
        end
    end

    tnal_map #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_wr_en (wr_en),
        .i_wr_bit(i_solid_in),
        .i_x_pos (i_x_pos),
        .i_y_pos (i_y_pos),
        .o_row_n (row_n),
        .o_row_c (row_c),
        .o_row_s (row_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind     <= i_kind;
            r_s1_solid_in <= i_solid_in;
            r_s1_x        <= i_x_pos;
            r_s1_in_c     <= in_grid;
            r_s1_ok_n     <= i_y_pos != '0;
            r_s1_ok_w     <= i_x_pos != '0;
            r_s1_ok_s     <= (int'(i_y_pos) + 1) < GRID_HEIGHT;
            r_s1_ok_e     <= (int'(i_x_pos) + 1) < GRID_WIDTH;
        end
    end

    assign xc = XW'(r_s1_x);
    assign xw = XW'(r_s1_x - tnal_pkg::X_W'(1));
    assign xe = XW'({1'b0, r_s1_x} + (tnal_pkg::X_W+1)'(1));

    assign b_n  = r_s1_ok_n ? row_n[xc] : r_edge_solid;
    assign b_s  = r_s1_ok_s ? row_s[xc] : r_edge_solid;
    assign b_w  = r_s1_ok_w ? row_c[xw] : r_edge_solid;
    assign b_e  = r_s1_ok_e ? row_c[xe] : r_edge_solid;
    assign b_nw = (r_s1_ok_n && r_s1_ok_w) ? row_n[xw] : r_edge_solid;
    assign b_ne = (r_s1_ok_n && r_s1_ok_e) ? row_n[xe] : r_edge_solid;
    assign b_sw = (r_s1_ok_s && r_s1_ok_w) ? row_s[xw] : r_edge_solid;
    assign b_se = (r_s1_ok_s && r_s1_ok_e) ? row_s[xe] : r_edge_solid;

    // The tile's own write is not in the RAM read yet: forward it.
    assign centre = r_s1_in_c && (r_s1_kind ? r_s1_solid_in : row_c[xc]);

    assign n_mask = centre ? {b_se & b_s & b_e, b_s, b_sw & b_s & b_w, b_e, b_w,
                              b_ne & b_n & b_e, b_n, b_nw & b_n & b_w}
                           : '0;
    assign n_atlas = tnal_pkg::atlas_lookup(n_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_tile_solid <= centre;
            r_mask       <= n_mask;
            r_atlas      <= n_atlas;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_tile_solid     = r_tile_solid;
    assign o_neighbour_mask = r_mask;
    assign o_atlas_col      = r_atlas.col;
    assign o_atlas_row      = r_atlas.row;

endmodule
